// File: rtl/core/dtcr_pkg.sv
// Shared types, widths and the divide-by-1023 helper for the dark theme colour remap.
// No dependencies; every other file imports this package.
`default_nettype none

package dtcr_pkg;

   localparam int FRAC_BITS = 10;
   localparam int REG_W     = 10;
   localparam int SQ_W      = FRAC_BITS + 1;   // saturation, 0 .. 2^F
   localparam int Z_W       = FRAC_BITS + 10;  // operand width of div1023
   localparam int SD_W      = FRAC_BITS + 10;  // saturation divider remainder
   localparam int KS_W      = REG_W + SQ_W;    // chroma weight k * S'
   localparam int BASE_W    = REG_W + 8;       // lr * d
   localparam int NUM_W     = FRAC_BITS + 31;  // channel dividend
   localparam int QCH_W     = 9;               // channel quotient bits
   localparam int LATENCY   = FRAC_BITS + 20;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_TEXT   = 3'd0,
      CSR_MAX_PANEL  = 3'd1,
      CSR_PANEL_L    = 3'd2,
      CSR_PANEL_CAP  = 3'd3,
      CSR_GREY_LIM   = 3'd4,
      CSR_GREY_L     = 3'd5,
      CSR_SAT_SCALE  = 3'd6
   } csr_idx_type;

   localparam logic [REG_W-1:0] RST_MIN_TEXT  = 10'd696;
   localparam logic [REG_W-1:0] RST_MAX_PANEL = 10'd563;
   localparam logic [REG_W-1:0] RST_PANEL_L   = 10'd194;
   localparam logic [REG_W-1:0] RST_PANEL_CAP = 10'd256;
   localparam logic [REG_W-1:0] RST_GREY_LIM  = 10'd184;
   localparam logic [REG_W-1:0] RST_GREY_L    = 10'd910;
   localparam logic [REG_W-1:0] RST_SAT_SCALE = 10'd972;

   typedef enum logic [2:0] {
      MODE_PANEL = 3'b001,
      MODE_GREY  = 3'b010,
      MODE_COLOR = 3'b100
   } mode_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
      logic       is_background;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       changed;
   } rsp_type;

   typedef struct packed {
      logic [REG_W-1:0] min_text_lightness;
      logic [REG_W-1:0] max_panel_lightness;
      logic [REG_W-1:0] panel_lightness;
      logic [REG_W-1:0] panel_saturation_cap;
      logic [REG_W-1:0] grey_saturation_limit;
      logic [REG_W-1:0] grey_text_lightness;
      logic [REG_W-1:0] saturation_scale;
   } cfg_type;

   // front end result, shared by all three channels
   typedef struct packed {
      logic              valid;
      logic              remap;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        mn;
      logic [7:0]        d;
      logic [REG_W-1:0]  lr;
      logic [BASE_W-1:0] base;
      logic [KS_W-1:0]   ks;
   } front_type;

   typedef struct packed {
      logic              valid;
      logic              remap;
      logic [7:0]        c;
      logic [7:0]        mn;
      logic [7:0]        d;
      logic [REG_W-1:0]  lr;
      logic [BASE_W-1:0] base;
      logic [KS_W-1:0]   ks;
   } chan_in_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
      logic [7:0] orig;
   } chan_out_type;

   // floor(z / 1023): z = 1023*a + (a + b), folded twice
   function automatic logic [Z_W-1:0] div1023(input logic [Z_W-1:0] z);
      logic [Z_W-1:0] a;
      logic [Z_W-1:0] s;
      logic [Z_W-1:0] c;
      logic [Z_W-1:0] s2;
      a  = z >> 10;
      s  = a + Z_W'(z[9:0]);
      c  = s >> 10;
      s2 = c + Z_W'(s[9:0]);
      return a + c + ((s2 >= Z_W'(1023)) ? Z_W'(1) : Z_W'(0));
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/dtcr_front.sv
// Front end: min/max, lightness tests, pipelined saturation divider, new saturation.
// Depends on dtcr_pkg.
`default_nettype none

module dtcr_front import dtcr_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire req_type   in_data,
   input  wire cfg_type   cfg,
   output front_type      out
);

   typedef struct packed {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [7:0]       mn;
      logic [7:0]       d;
      logic             remap;
      mode_type         mode;
      logic [REG_W-1:0] lr;
   } carry_type;

   // stage 0: input register
   logic    v0_ff;
   req_type r0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= in_valid;
      r0_ff <= in_data;
   end

   // stage 1: extremes
   logic [7:0] mx_in, mn_in;
   logic       v1_ff;
   req_type    r1_ff;
   logic [7:0] mn1_ff, d1_ff;
   logic [8:0] sum1_ff;

   always_comb begin
      mx_in = r0_ff.red_in;
      if (r0_ff.green_in > mx_in) mx_in = r0_ff.green_in;
      if (r0_ff.blue_in > mx_in) mx_in = r0_ff.blue_in;
      mn_in = r0_ff.red_in;
      if (r0_ff.green_in < mn_in) mn_in = r0_ff.green_in;
      if (r0_ff.blue_in < mn_in) mn_in = r0_ff.blue_in;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v0_ff;
      r1_ff   <= r0_ff;
      mn1_ff  <= mn_in;
      d1_ff   <= mx_in - mn_in;
      sum1_ff <= {1'b0, mx_in} + {1'b0, mn_in};
   end

   // stage 2: decisions and divider setup
   logic [8:0]  den_in;
   logic [18:0] sum_x;
   logic        bright_in, dark_in, grey_in, remap_in;
   mode_type    mode_in;
   logic [REG_W-1:0] lr_in;

   always_comb begin
      den_in    = (sum1_ff <= 9'd255) ? sum1_ff : 9'(10'd510 - {1'b0, sum1_ff});
      sum_x     = 19'(sum1_ff) * 19'd1023;
      bright_in = sum_x > 19'(cfg.max_panel_lightness) * 19'd510;
      dark_in   = sum_x < 19'(cfg.min_text_lightness) * 19'd510;
      if (d1_ff == 8'd0) grey_in = cfg.grey_saturation_limit != '0;
      else grey_in = 19'(d1_ff) * 19'd1023 < 19'(cfg.grey_saturation_limit) * 19'(den_in);
      remap_in = (r1_ff.alpha_in != 8'd0) &&
                 (r1_ff.is_background ? bright_in : dark_in);
      if (r1_ff.is_background) begin
         mode_in = MODE_PANEL;
         lr_in   = cfg.panel_lightness;
      end else if (grey_in) begin
         mode_in = MODE_GREY;
         lr_in   = cfg.grey_text_lightness;
      end else begin
         mode_in = MODE_COLOR;
         lr_in   = cfg.min_text_lightness;
      end
   end

   // saturation divider: round(d*2^F/den) = floor((d*2^(F+1)+den) / (2*den))
   logic            vld_ff  [0:SQ_W];
   logic [SD_W-1:0] rem_ff  [0:SQ_W];
   logic [8:0]      dsor_ff [0:SQ_W];
   logic [SQ_W-1:0] quo_ff  [0:SQ_W];
   carry_type       car_ff  [0:SQ_W];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= v1_ff;
      rem_ff[0]        <= (SD_W'(d1_ff) << (FRAC_BITS + 1)) + SD_W'(den_in);
      dsor_ff[0]       <= {den_in[7:0], 1'b0};
      quo_ff[0]        <= '0;
      car_ff[0].red    <= r1_ff.red_in;
      car_ff[0].green  <= r1_ff.green_in;
      car_ff[0].blue   <= r1_ff.blue_in;
      car_ff[0].mn     <= mn1_ff;
      car_ff[0].d      <= d1_ff;
      car_ff[0].remap  <= remap_in;
      car_ff[0].mode   <= mode_in;
      car_ff[0].lr     <= lr_in;
   end

   for (genvar i = 1; i <= SQ_W; i++) begin : g_sq
      localparam int J = SQ_W - i;
      logic [SD_W-1:0] dsh;
      logic            take;
      assign dsh  = SD_W'(dsor_ff[i-1]) << J;
      assign take = rem_ff[i-1] >= dsh;
      always_ff @(posedge clock) begin
         if (reset) vld_ff[i] <= 1'b0;
         else vld_ff[i] <= vld_ff[i-1];
         rem_ff[i]  <= take ? rem_ff[i-1] - dsh : rem_ff[i-1];
         quo_ff[i]  <= quo_ff[i-1] | (take ? (SQ_W'(1) << J) : '0);
         dsor_ff[i] <= dsor_ff[i-1];
         car_ff[i]  <= car_ff[i-1];
      end
   end

   // stage A: scale product, panel cap
   logic             va_ff;
   carry_type        ca_ff;
   logic [SQ_W-1:0]  sqa_ff, capa_ff;
   logic [Z_W-1:0]   proda_ff;
   logic [Z_W-1:0]   cap_in;

   assign cap_in = div1023((Z_W'(cfg.panel_saturation_cap) << FRAC_BITS) + Z_W'(511));

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else va_ff <= vld_ff[SQ_W];
      ca_ff    <= car_ff[SQ_W];
      sqa_ff   <= quo_ff[SQ_W];
      proda_ff <= Z_W'(quo_ff[SQ_W]) * Z_W'(cfg.saturation_scale);
      capa_ff  <= cap_in[SQ_W-1:0];
   end

   // stage B: new saturation and chroma weight
   logic [Z_W-1:0]   col_in;
   logic [SQ_W-1:0]  snew_in;
   logic [REG_W-1:0] k_in, lfold;
   logic             vb_ff;
   carry_type        cb_ff;
   logic [SQ_W-1:0]  snewb_ff;
   logic [REG_W-1:0] kb_ff;

   always_comb begin
      col_in = div1023(proda_ff + Z_W'(511));
      case (ca_ff.mode)
         MODE_PANEL: snew_in = (sqa_ff < capa_ff) ? sqa_ff : capa_ff;
         MODE_GREY:  snew_in = sqa_ff;
         default:    snew_in = col_in[SQ_W-1:0];
      endcase
      // k = 1023 - |2*lr - 1023|
      lfold = ca_ff.lr[9] ? ~ca_ff.lr : ca_ff.lr;
      k_in  = {lfold[8:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= va_ff;
      cb_ff    <= ca_ff;
      snewb_ff <= snew_in;
      kb_ff    <= k_in;
   end

   // stage C: shared products
   logic              vc_ff;
   carry_type         cc_ff;
   logic [BASE_W-1:0] basec_ff;
   logic [KS_W-1:0]   ksc_ff;

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else vc_ff <= vb_ff;
      cc_ff    <= cb_ff;
      basec_ff <= BASE_W'(cb_ff.lr) * BASE_W'(cb_ff.d);
      ksc_ff   <= KS_W'(kb_ff) * KS_W'(snewb_ff);
   end

   always_comb begin
      out.valid = vc_ff;
      out.remap = cc_ff.remap;
      out.red   = cc_ff.red;
      out.green = cc_ff.green;
      out.blue  = cc_ff.blue;
      out.mn    = cc_ff.mn;
      out.d     = cc_ff.d;
      out.lr    = cc_ff.lr;
      out.base  = basec_ff;
      out.ks    = ksc_ff;
   end

endmodule

`default_nettype wire

// File: rtl/core/dtcr_chan.sv
// One output channel: numerator build, 9-step pipelined divider by the chroma span, clamp.
// Depends on dtcr_pkg.
`default_nettype none

module dtcr_chan import dtcr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire chan_in_type ci,
   output chan_out_type     co
);

   localparam int T_W   = 10;
   localparam int P_W   = KS_W + 1 + T_W;
   localparam int SUM_W = FRAC_BITS + 23;
   localparam int SN_W  = SUM_W + 8;

   typedef struct packed {
      logic             remap;
      logic [7:0]       c;
      logic             grey;
      logic [7:0]       gval;
   } tail_type;

   // stage 1: chroma term k*S'*(2*(c-mn)-d)
   logic signed [T_W-1:0] t_in;
   logic                  v1_ff;
   chan_in_type           c1_ff;
   logic signed [P_W-1:0] p1_ff;

   assign t_in = $signed({1'b0, ci.c - ci.mn, 1'b0}) - $signed({2'b00, ci.d});

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= ci.valid;
      c1_ff <= ci;
      p1_ff <= $signed({1'b0, ci.ks}) * P_W'(t_in);
   end

   // stage 2: dividend and divisor
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SN_W-1:0]  num_in;
   logic [NUM_W-1:0]        dch_in, n_in;
   logic [Z_W-1:0]          g_in;

   always_comb begin
      sum_in = $signed(SUM_W'(c1_ff.base) << (FRAC_BITS + 1)) + SUM_W'(p1_ff);
      num_in = (SN_W'(sum_in) <<< 8) - SN_W'(sum_in);
      dch_in = (NUM_W'(c1_ff.d) * NUM_W'(1023)) << (FRAC_BITS + 1);
      n_in   = (num_in < 0) ? dch_in : (NUM_W'(num_in) << 1) + dch_in;
      g_in   = div1023(Z_W'(c1_ff.lr) * Z_W'(255) + Z_W'(511));
   end

   logic             vld_ff [0:QCH_W];
   logic [NUM_W-1:0] rem_ff [0:QCH_W];
   logic [NUM_W-1:0] dv_ff  [0:QCH_W];
   logic [QCH_W-1:0] quo_ff [0:QCH_W];
   tail_type         tl_ff  [0:QCH_W];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= v1_ff;
      rem_ff[0]      <= n_in;
      dv_ff[0]       <= dch_in << 1;
      quo_ff[0]      <= '0;
      tl_ff[0].remap <= c1_ff.remap;
      tl_ff[0].c     <= c1_ff.c;
      tl_ff[0].grey  <= c1_ff.d == 8'd0;
      tl_ff[0].gval  <= g_in[7:0];
   end

   for (genvar i = 1; i <= QCH_W; i++) begin : g_div
      localparam int J = QCH_W - i;
      logic [NUM_W-1:0] dsh;
      logic             take;
      assign dsh  = dv_ff[i-1] << J;
      assign take = rem_ff[i-1] >= dsh;
      always_ff @(posedge clock) begin
         if (reset) vld_ff[i] <= 1'b0;
         else vld_ff[i] <= vld_ff[i-1];
         rem_ff[i] <= take ? rem_ff[i-1] - dsh : rem_ff[i-1];
         quo_ff[i] <= quo_ff[i-1] | (take ? (QCH_W'(1) << J) : '0);
         dv_ff[i]  <= dv_ff[i-1];
         tl_ff[i]  <= tl_ff[i-1];
      end
   end

   // final: clamp and select
   logic [7:0] val_in;
   logic       vo_ff;
   logic [7:0] val_ff, orig_ff;
   tail_type   tl;

   always_comb begin
      tl = tl_ff[QCH_W];
      if (!tl.remap) val_in = tl.c;
      else if (tl.grey) val_in = tl.gval;
      else if (quo_ff[QCH_W][QCH_W-1:8] != '0) val_in = 8'd255;
      else val_in = quo_ff[QCH_W][7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else vo_ff <= vld_ff[QCH_W];
      val_ff  <= val_in;
      orig_ff <= tl.c;
   end

   assign co.valid = vo_ff;
   assign co.value = val_ff;
   assign co.orig  = orig_ff;

endmodule

`default_nettype wire

// File: rtl/core/dark_theme_colour_remap_top.sv
// Each result strobes after the front end, channel pipes and output register.
// Throughput: one item per cycle; busy is low except during reset.
// Depth is set by the bit-per-stage saturation divider (FRAC_BITS + 1 stages)
// and the 9-stage channel dividers. Reset is synchronous, clears all valid bits
// and returns the registers to their defaults. The receiver cannot stall.
// Top level: register file, front end, three channel pipes. Depends on dtcr_pkg,
// dtcr_front, dtcr_chan.
`default_nettype none

module dark_theme_colour_remap_top import dtcr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   cfg_type cfg_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_text_lightness    <= RST_MIN_TEXT;
         cfg_ff.max_panel_lightness   <= RST_MAX_PANEL;
         cfg_ff.panel_lightness       <= RST_PANEL_L;
         cfg_ff.panel_saturation_cap  <= RST_PANEL_CAP;
         cfg_ff.grey_saturation_limit <= RST_GREY_LIM;
         cfg_ff.grey_text_lightness   <= RST_GREY_L;
         cfg_ff.saturation_scale      <= RST_SAT_SCALE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MIN_TEXT:  cfg_ff.min_text_lightness    <= csr_wdata;
            CSR_MAX_PANEL: cfg_ff.max_panel_lightness   <= csr_wdata;
            CSR_PANEL_L:   cfg_ff.panel_lightness       <= csr_wdata;
            CSR_PANEL_CAP: cfg_ff.panel_saturation_cap  <= csr_wdata;
            CSR_GREY_LIM:  cfg_ff.grey_saturation_limit <= csr_wdata;
            CSR_GREY_L:    cfg_ff.grey_text_lightness   <= csr_wdata;
            CSR_SAT_SCALE: cfg_ff.saturation_scale      <= csr_wdata;
            default: ;
         endcase
      end
   end

   front_type    fr;
   chan_in_type  ci_r, ci_g, ci_b;
   chan_out_type co_r, co_g, co_b;

   dtcr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .cfg      (cfg_ff),
      .out      (fr)
   );

   always_comb begin
      ci_r.valid = fr.valid;
      ci_r.remap = fr.remap;
      ci_r.c     = fr.red;
      ci_r.mn    = fr.mn;
      ci_r.d     = fr.d;
      ci_r.lr    = fr.lr;
      ci_r.base  = fr.base;
      ci_r.ks    = fr.ks;
      ci_g       = ci_r;
      ci_g.c     = fr.green;
      ci_b       = ci_r;
      ci_b.c     = fr.blue;
   end

   dtcr_chan u_chan_r (.clock(clock), .reset(reset), .ci(ci_r), .co(co_r));
   dtcr_chan u_chan_g (.clock(clock), .reset(reset), .ci(ci_g), .co(co_g));
   dtcr_chan u_chan_b (.clock(clock), .reset(reset), .ci(ci_b), .co(co_b));

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.red_out   = co_r.value;
      rsp_in.green_out = co_g.value;
      rsp_in.blue_out  = co_b.value;
      rsp_in.changed   = (co_r.value != co_r.orig) || (co_g.value != co_g.orig) ||
                         (co_b.value != co_b.orig);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= co_r.valid && co_g.valid && co_b.valid;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/dtcr_checker.sv
// Port-level checks on the colour remap top level, bound to it below.
// Depends on dtcr_pkg and dark_theme_colour_remap_top.
`default_nettype none

module dtcr_checker import dtcr_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // every taken item yields a result after the pipeline latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after item");

   // no result without a matching taken item
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without item");

   // transparent colours pass through untouched
   a_transparent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.alpha_in == 8'd0) |-> ##LATENCY
      (!rsp_data.changed && rsp_data.red_out == $past(req_data.red_in, LATENCY) &&
       rsp_data.green_out == $past(req_data.green_in, LATENCY) &&
       rsp_data.blue_out == $past(req_data.blue_in, LATENCY)))
      else $error("transparent item altered");

   // changed flag agrees with the channels
   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.changed ==
         ((rsp_data.red_out != $past(req_data.red_in, LATENCY)) ||
          (rsp_data.green_out != $past(req_data.green_in, LATENCY)) ||
          (rsp_data.blue_out != $past(req_data.blue_in, LATENCY))))
      else $error("changed flag wrong");

endmodule

bind dark_theme_colour_remap_top dtcr_checker u_dtcr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: tb/dark_theme_colour_remap_top_tb.sv
// Testbench for the dark theme colour remap: directed table, then random colours,
// each result checked against a typed row or a remap model. Depends on dtcr_pkg.
`timescale 1ns / 100ps

module dark_theme_colour_remap_top_tb;
   import dtcr_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   dark_theme_colour_remap_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   localparam int  FB        = 10;
   localparam int  CYCLE_CAP = 400000;

   typedef struct {
      req_type req;
      logic    known;   // expected result typed in
      rsp_type rsp;
   } vec_type;

   logic [REG_W-1:0] cfg [7];
   rsp_type          pending_colors [$];
   int               errors;
   int               cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic logic [7:0] remap_channel(int c, int mn, int d, int lr, int sq);
      longint k, num, den, v;
      if (d == 0) return 8'(rdiv(255 * lr, 1023));
      k = 2 * lr - 1023;
      if (k < 0) k = -k;
      k = 1023 - k;
      num = 255 * (longint'(lr) * (1 << FB) * 2 * d + k * sq * (2 * (c - mn) - d));
      if (num < 0) num = 0;
      den = 1023 * (1 << FB) * 2 * longint'(d);
      v = (2 * num + den) / (2 * den);
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   function automatic rsp_type remap_color(req_type q);
      rsp_type o;
      int r, g, b, mx, mn, d, sum, den, sq, snew, lr, cap;
      bit remap, grey;
      r = q.red_in; g = q.green_in; b = q.blue_in;
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      d = mx - mn;
      sum = mx + mn;
      den = (sum <= 255) ? sum : 510 - sum;
      sq = (d == 0) ? 0 : int'(rdiv(longint'(d) << FB, den));
      snew = 0; lr = 0; remap = 0;
      if (q.alpha_in != 0) begin
         if (q.is_background) begin
            if (sum * 1023 > int'(cfg[CSR_MAX_PANEL]) * 510) begin
               cap = int'(rdiv(longint'(cfg[CSR_PANEL_CAP]) << FB, 1023));
               snew = sq < cap ? sq : cap;
               lr = cfg[CSR_PANEL_L];
               remap = 1;
            end
         end else if (sum * 1023 < int'(cfg[CSR_MIN_TEXT]) * 510) begin
            if (d == 0) grey = cfg[CSR_GREY_LIM] > 0;
            else grey = d * 1023 < int'(cfg[CSR_GREY_LIM]) * den;
            if (grey) begin
               snew = sq;
               lr = cfg[CSR_GREY_L];
            end else begin
               snew = int'(rdiv(longint'(sq) * cfg[CSR_SAT_SCALE], 1023));
               lr = cfg[CSR_MIN_TEXT];
            end
            remap = 1;
         end
      end
      if (remap) begin
         o.red_out   = remap_channel(r, mn, d, lr, snew);
         o.green_out = remap_channel(g, mn, d, lr, snew);
         o.blue_out  = remap_channel(b, mn, d, lr, snew);
      end else begin
         o.red_out = 8'(r); o.green_out = 8'(g); o.blue_out = 8'(b);
      end
      o.changed = (o.red_out != r) || (o.green_out != g) || (o.blue_out != b);
      return o;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_colors.size() == 0) begin
            $error("result with nothing expected: %h", rsp_data);
            errors++;
         end else begin
            want = pending_colors.pop_front();
            if (rsp_data.red_out !== want.red_out) begin
               $error("red_out expected %0d got %0d", want.red_out, rsp_data.red_out);
               errors++;
            end
            if (rsp_data.green_out !== want.green_out) begin
               $error("green_out expected %0d got %0d", want.green_out, rsp_data.green_out);
               errors++;
            end
            if (rsp_data.blue_out !== want.blue_out) begin
               $error("blue_out expected %0d got %0d", want.blue_out, rsp_data.blue_out);
               errors++;
            end
            if (rsp_data.changed !== want.changed) begin
               $error("changed expected %0d got %0d", want.changed, rsp_data.changed);
               errors++;
            end
         end
      end
   end

   // idle gap of random length, never empty, so start is never driven twice in one step
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      repeat (n) @(posedge clock);
   endtask

   // valid stays high across consecutive writes; write_all drops it at the end
   task automatic write_reg(csr_idx_type idx, logic [REG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg[idx] = val;
   endtask

   task automatic write_all(logic [REG_W-1:0] v [7]);
      for (int i = 0; i < 7; i++) write_reg(csr_idx_type'(i), v[i]);
      csr_valid <= 1'b0;
   endtask

   // hand one colour over; start stays high across back-to-back items
   task automatic send_color(req_type q, bit gaps, bit known, rsp_type typed);
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_colors.push_back(known ? typed : remap_color(q));
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         idle_gap();
      end
   endtask

   task automatic drain();
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic req_type rand_color(int mode);
      req_type q;
      q = req_type'($urandom);
      q.alpha_in = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom);
      case (mode)
         0: begin       // light backgrounds
            q.is_background = 1'b1;
            q.red_in = 8'($urandom_range(110, 255));
            q.green_in = 8'($urandom_range(110, 255));
            q.blue_in = 8'($urandom_range(110, 255));
         end
         1: begin       // dark text, sometimes near grey
            q.is_background = 1'b0;
            q.red_in = 8'($urandom_range(0, 190));
            if ($urandom_range(0, 1)) begin
               q.green_in = 8'(q.red_in + $urandom_range(0, 12));
               q.blue_in  = 8'(q.red_in + $urandom_range(0, 12));
            end else begin
               q.green_in = 8'($urandom_range(0, 190));
               q.blue_in  = 8'($urandom_range(0, 190));
            end
         end
         default: ;
      endcase
      return q;
   endfunction

   initial begin
      vec_type          vecs [$];
      vec_type          v;
      logic [REG_W-1:0] set [7];
      rsp_type          none;
      errors = 0;
      cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MIN_TEXT;
      csr_wdata = '0;
      cfg[CSR_MIN_TEXT] = RST_MIN_TEXT;   cfg[CSR_MAX_PANEL] = RST_MAX_PANEL;
      cfg[CSR_PANEL_L] = RST_PANEL_L;     cfg[CSR_PANEL_CAP] = RST_PANEL_CAP;
      cfg[CSR_GREY_LIM] = RST_GREY_LIM;   cfg[CSR_GREY_L] = RST_GREY_L;
      cfg[CSR_SAT_SCALE] = RST_SAT_SCALE;
      none = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under reset defaults; typed rows read off at a glance
      v.known = 1;
      v.req = '{8'd255, 8'd255, 8'd255, 8'd0, 1'b1};   // transparent white bg
      v.rsp = '{8'd255, 8'd255, 8'd255, 1'b0};        vecs.push_back(v);
      v.req = '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}; // white bg -> 255*194/1023
      v.rsp = '{8'd48, 8'd48, 8'd48, 1'b1};           vecs.push_back(v);
      v.req = '{8'd0, 8'd0, 8'd0, 8'd255, 1'b1};       // black bg passes
      v.rsp = '{8'd0, 8'd0, 8'd0, 1'b0};              vecs.push_back(v);
      v.req = '{8'd0, 8'd0, 8'd0, 8'd1, 1'b0};         // black text -> grey text
      v.rsp = '{8'd227, 8'd227, 8'd227, 1'b1};        vecs.push_back(v);
      v.req = '{8'd255, 8'd255, 8'd255, 8'd128, 1'b0}; // white text passes
      v.rsp = '{8'd255, 8'd255, 8'd255, 1'b0};        vecs.push_back(v);
      v.known = 0;
      v.rsp = none;
      v.req = '{8'd255, 8'd0, 8'd0, 8'd255, 1'b0};     vecs.push_back(v);
      v.req = '{8'd0, 8'd0, 8'd255, 8'd255, 1'b0};     vecs.push_back(v);
      v.req = '{8'd0, 8'd255, 8'd0, 8'd255, 1'b1};     vecs.push_back(v);
      v.req = '{8'd255, 8'd200, 8'd200, 8'd255, 1'b1}; vecs.push_back(v);
      v.req = '{8'd60, 8'd64, 8'd62, 8'd255, 1'b0};    vecs.push_back(v);
      v.req = '{8'd128, 8'd0, 8'd255, 8'd170, 1'b0};   vecs.push_back(v);
      v.req = '{8'd170, 8'd85, 8'd85, 8'd85, 1'b1};    vecs.push_back(v);
      v.req = '{8'd144, 8'd144, 8'd144, 8'd255, 1'b1}; vecs.push_back(v);
      v.req = '{8'd143, 8'd143, 8'd143, 8'd255, 1'b1}; vecs.push_back(v);
      foreach (vecs[i]) send_color(vecs[i].req, 1'b0, vecs[i].known, vecs[i].rsp);
      start <= 1'b0;
      drain();

      // several register settings, extremes included
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set = '{696, 563, 194, 256, 184, 910, 972};
            1: set = '{1023, 0, 0, 1023, 0, 1023, 1023};
            2: set = '{0, 1023, 1023, 0, 1023, 0, 0};
            3: set = '{1023, 0, 1023, 0, 1023, 511, 512};
            4: set = '{512, 511, 511, 512, 1, 1, 1};
            default: foreach (set[i]) set[i] = 10'($urandom);
         endcase
         if (phase == 2) begin
            // out-of-range index must be ignored; write_all follows directly
            csr_valid <= 1'b1;
            csr_index <= 3'd7;
            csr_wdata <= 10'h3ff;
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
         end
         write_all(set);
         for (int n = 0; n < 200; n++)
            send_color(rand_color($urandom_range(0, 2)), phase % 3 != 1, 1'b0, none);
         start <= 1'b0;
         drain();
      end

      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/dtcr_pkg.sv
rtl/core/dtcr_front.sv
rtl/core/dtcr_chan.sv
rtl/core/dark_theme_colour_remap_top.sv
rtl/core/dtcr_checker.sv
tb/dark_theme_colour_remap_top_tb.sv
